// ----- sv/mcfp_pkg.sv -----
package mcfp_pkg;

  // lane order: position, velocity, kp, kd, torque
  localparam int NUM_LANES          = 5;
  localparam int POSITION_CODE_BITS = 16;
  localparam int OTHER_CODE_BITS    = 12;
  localparam int ID_W               = 8;
  localparam int SET_W              = 32;
  localparam int PAYLOAD_W          = 64;

  // offset x - lo: at most 500.0 in Q16.16, below 2^25
  localparam int D_W    = 25;
  // offset times full scale
  localparam int PROD_W = D_W + POSITION_CODE_BITS;
  // scaled offset after the 2^16 divide, at most 500 * 4095
  localparam int M_W    = 21;
  localparam int K_W    = 9;
  localparam int RCP_W  = 30;
  localparam int RCP_SH = 32;
  localparam int RP_W   = M_W + RCP_W;
  localparam int CODE_W = POSITION_CODE_BITS;

  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_KP  = 2;
  localparam int LANE_KD  = 3;
  localparam int LANE_TRQ = 4;

  typedef logic [NUM_LANES-1:0][SET_W-1:0]  setpt_vec_t;
  typedef logic [NUM_LANES-1:0][CODE_W-1:0] code_vec_t;

  // range ends in Q16.16
  localparam logic signed [SET_W-1:0] LANE_LO [NUM_LANES] = '{
    -32'sd819200, -32'sd2981888, 32'sd0, 32'sd0, -32'sd327680
  };
  localparam logic signed [SET_W-1:0] LANE_HI [NUM_LANES] = '{
    32'sd819200, 32'sd2981888, 32'sd32768000, 32'sd327680, 32'sd327680
  };

  // full-scale code per lane
  localparam logic [CODE_W-1:0] LANE_FULL [NUM_LANES] = '{
    16'd65535, 16'd4095, 16'd4095, 16'd4095, 16'd4095
  };

  // span is K * 2^16; divide by K through floor(2^32 / K)
  localparam logic [K_W-1:0] LANE_K [NUM_LANES] = '{
    9'd25, 9'd91, 9'd500, 9'd5, 9'd10
  };
  localparam logic [RCP_W-1:0] LANE_RCP [NUM_LANES] = '{
    30'd171798691, 30'd47197442, 30'd8589934, 30'd858993459, 30'd429496729
  };

endpackage

// ----- sv/mcfp_scale_pipe.sv -----
module mcfp_scale_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [mcfp_pkg::ID_W-1:0] in_id,
  input  mcfp_pkg::setpt_vec_t      in_set,
  output logic                      out_vld,
  output logic [mcfp_pkg::ID_W-1:0] out_id,
  output mcfp_pkg::code_vec_t       out_code
);
  import mcfp_pkg::*;

  // valid bits of the four stages
  logic [3:0]      vld_r;
  logic [3:0]      vld_nxt;
  logic [ID_W-1:0] id1_r, id2_r, id3_r, id4_r;

  logic [D_W-1:0]    d_r    [NUM_LANES];
  logic [D_W-1:0]    d_nxt  [NUM_LANES];
  logic [M_W-1:0]    m2_r   [NUM_LANES];
  logic [M_W-1:0]    m2_nxt [NUM_LANES];
  logic [M_W-1:0]    m3_r   [NUM_LANES];
  logic [CODE_W-1:0] q3_r   [NUM_LANES];
  logic [CODE_W-1:0] q3_nxt [NUM_LANES];
  logic [CODE_W-1:0] q4_r   [NUM_LANES];
  logic [CODE_W-1:0] q4_nxt [NUM_LANES];

  // stage 1: clamp to range and take offset from the low end
  always_comb begin
    logic signed [SET_W-1:0] x;
    logic signed [SET_W-1:0] c;
    logic signed [SET_W:0]   diff;
    for (int i = 0; i < NUM_LANES; i++) begin
      x = signed'(in_set[i]);
      if (x < LANE_LO[i]) begin
        c = LANE_LO[i];
      end else if (x > LANE_HI[i]) begin
        c = LANE_HI[i];
      end else begin
        c = x;
      end
      diff     = {c[SET_W-1], c} - {LANE_LO[i][SET_W-1], LANE_LO[i]};
      d_nxt[i] = diff[D_W-1:0];
    end
  end

  // stage 2: scale by full code, drop the Q16.16 fraction
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int i = 0; i < NUM_LANES; i++) begin
      prod      = PROD_W'(d_r[i]) * PROD_W'(LANE_FULL[i]);
      m2_nxt[i] = prod[M_W+15:16];
    end
  end

  // stage 3: reciprocal estimate of m / K, low by at most one
  always_comb begin
    logic [RP_W-1:0] rp;
    for (int i = 0; i < NUM_LANES; i++) begin
      rp        = RP_W'(m2_r[i]) * RP_W'(LANE_RCP[i]);
      q3_nxt[i] = rp[RCP_SH+CODE_W-1:RCP_SH];
    end
  end

  // stage 4: fix up the estimate with one compare
  always_comb begin
    logic [M_W-1:0] qk;
    logic [M_W-1:0] rem;
    for (int i = 0; i < NUM_LANES; i++) begin
      qk  = M_W'(q3_r[i]) * M_W'(LANE_K[i]);
      rem = m3_r[i] - qk;
      if (rem >= M_W'(LANE_K[i])) begin
        q4_nxt[i] = q3_r[i] + CODE_W'(1);
      end else begin
        q4_nxt[i] = q3_r[i];
      end
    end
  end

  // advance valid bits
  assign vld_nxt = {vld_r[2:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // data stages carry no reset
  always_ff @(posedge clk) begin
    id1_r <= in_id;
    id2_r <= id1_r;
    id3_r <= id2_r;
    id4_r <= id3_r;
    for (int i = 0; i < NUM_LANES; i++) begin
      d_r[i]  <= d_nxt[i];
      m2_r[i] <= m2_nxt[i];
      m3_r[i] <= m2_r[i];
      q3_r[i] <= q3_nxt[i];
      q4_r[i] <= q4_nxt[i];
    end
  end

  assign out_vld = vld_r[3];
  assign out_id  = id4_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      out_code[i] = q4_r[i];
    end
  end

endmodule

// ----- sv/motor_command_frame_packer_top.sv -----
// Throughput: one word per cycle; start may stay high every cycle, busy stays low.
// Five pipeline registers: clamp, full-scale multiply, reciprocal multiply,
// remainder fix-up, frame pack. The receiver cannot stall the output strobe.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module motor_command_frame_packer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mcfp_pkg::ID_W-1:0]      in_motor_id,
  input  logic signed [mcfp_pkg::SET_W-1:0] in_position_target,
  input  logic signed [mcfp_pkg::SET_W-1:0] in_velocity_target,
  input  logic signed [mcfp_pkg::SET_W-1:0] in_stiffness_gain,
  input  logic signed [mcfp_pkg::SET_W-1:0] in_damping_gain,
  input  logic signed [mcfp_pkg::SET_W-1:0] in_torque_feedforward,
  output logic                           out_valid,
  output logic [mcfp_pkg::ID_W-1:0]      out_frame_id,
  output logic [mcfp_pkg::PAYLOAD_W-1:0] out_frame_payload
);
  import mcfp_pkg::*;

  setpt_vec_t       set_vec;
  logic             pipe_vld;
  logic [ID_W-1:0]  pipe_id;
  code_vec_t        pipe_code;

  logic                 valid_r;
  logic [ID_W-1:0]      frame_id_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [PAYLOAD_W-1:0] payload_nxt;

  // the pipeline never stalls
  assign busy = 1'b0;

  always_comb begin
    set_vec           = '0;
    set_vec[LANE_POS] = in_position_target;
    set_vec[LANE_VEL] = in_velocity_target;
    set_vec[LANE_KP]  = in_stiffness_gain;
    set_vec[LANE_KD]  = in_damping_gain;
    set_vec[LANE_TRQ] = in_torque_feedforward;
  end

  mcfp_scale_pipe u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_id    (in_motor_id),
    .in_set   (set_vec),
    .out_vld  (pipe_vld),
    .out_id   (pipe_id),
    .out_code (pipe_code)
  );

  // pack codes big-endian, position on top
  assign payload_nxt = {
    pipe_code[LANE_POS][POSITION_CODE_BITS-1:0],
    pipe_code[LANE_VEL][OTHER_CODE_BITS-1:0],
    pipe_code[LANE_KP][OTHER_CODE_BITS-1:0],
    pipe_code[LANE_KD][OTHER_CODE_BITS-1:0],
    pipe_code[LANE_TRQ][OTHER_CODE_BITS-1:0]
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pipe_vld;
    end
  end

  always_ff @(posedge clk) begin
    frame_id_r <= pipe_id;
    payload_r  <= payload_nxt;
  end

  assign out_valid         = valid_r;
  assign out_frame_id      = frame_id_r;
  assign out_frame_payload = payload_r;

endmodule
